// ===== design/gicc_pkg.sv =====
// ----------------------------------------------------------------------------
// gicc_pkg
// shared widths, register indexes and codes of the grid index converter
// ----------------------------------------------------------------------------
package gicc_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int QUEUE_DEPTH     = 2;

  // fixed field widths
  localparam int SIZE_W    = 11;
  localparam int SPC_W     = 24;
  localparam int ORG_W     = 40;
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 30;
  localparam int CRD_W     = 10;
  localparam int POS_W     = 48;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd6;

  // reset values
  localparam int SIZE_MIN      = 2;
  localparam int RESET_SIZE    = 2;
  localparam int RESET_SPACING = 65536;

  // commands and error codes
  localparam logic CMD_TO_INDEX = 1'b0;
  localparam logic CMD_TO_COORD = 1'b1;
  localparam logic ERR_NONE     = 1'b0;
  localparam logic ERR_OUTSIDE  = 1'b1;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } gicc_q_stat_t;

endpackage

// ===== design/gicc_front.sv =====
// ----------------------------------------------------------------------------
// gicc_front
// accepts beats, range checks them and linearizes coordinates
// ----------------------------------------------------------------------------
module gicc_front import gicc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [COORD_W-1:0]            in_coord_x,
  input  logic [COORD_W-1:0]            in_coord_y,
  input  logic [COORD_W-1:0]            in_coord_z,
  input  logic [IDX_W-1:0]              in_point_index,
  input  logic [$clog2(MAX_DIM+1)-1:0]  nx,
  input  logic [$clog2(MAX_DIM+1)-1:0]  ny,
  input  logic [$clog2(MAX_DIM+1)-1:0]  nz,
  input  logic [3*$clog2(MAX_DIM+1)-1:0] total,
  input  gicc_q_stat_t                  q_stat,
  output logic                          push,
  output logic [2+IDX_W+3*$clog2(MAX_DIM)-1:0] push_data
);

  localparam int SZ_W  = $clog2(MAX_DIM+1);
  localparam int CQ_W  = $clog2(MAX_DIM);
  localparam int T_W   = SZ_W + CQ_W;
  localparam int X_W   = SZ_W + T_W;
  localparam int ENT_W = 2 + IDX_W + 3*CQ_W;

  logic               en;
  logic               s1_v_r, s1_cmd_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               s2_v_r, s2_cmd_r, s2_ok_r;
  logic [CQ_W-1:0]    s2_x_r, s2_y_r, s2_z_r;
  logic [T_W-1:0]     s2_t_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic               s3_v_r;
  logic [ENT_W-1:0]   s3_data_r;

  logic               ok2_nxt;
  logic [CQ_W-1:0]    x2_nxt, y2_nxt, z2_nxt;
  logic [T_W-1:0]     t2_nxt;
  logic               ok3_nxt;
  logic [X_W-1:0]     lin3;
  logic [IDX_W-1:0]   idx3_nxt;

  assign en        = !s3_v_r || !q_stat.full;
  assign in_ready  = en;
  assign push      = en && s3_v_r;
  assign push_data = s3_data_r;

  // bounds check on signed coordinates, then y + ny*z
  always_comb begin
    ok2_nxt = !s1_x_r[COORD_W-1] && (32'(s1_x_r) < 32'(nx)) &&
              !s1_y_r[COORD_W-1] && (32'(s1_y_r) < 32'(ny)) &&
              !s1_z_r[COORD_W-1] && (32'(s1_z_r) < 32'(nz));
    x2_nxt  = ok2_nxt ? CQ_W'(s1_x_r) : '0;
    y2_nxt  = ok2_nxt ? CQ_W'(s1_y_r) : '0;
    z2_nxt  = ok2_nxt ? CQ_W'(s1_z_r) : '0;
    t2_nxt  = T_W'(y2_nxt) + T_W'(ny) * T_W'(z2_nxt);
  end

  // x + nx*t, and the index range check
  always_comb begin
    lin3     = X_W'(s2_x_r) + X_W'(nx) * X_W'(s2_t_r);
    ok3_nxt  = (s2_cmd_r == CMD_TO_COORD) ? (64'(s2_idx_r) < 64'(total)) : s2_ok_r;
    idx3_nxt = (s2_cmd_r == CMD_TO_COORD) ? s2_idx_r : IDX_W'(lin3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r  <= in_cmd;
      s1_x_r    <= in_coord_x;
      s1_y_r    <= in_coord_y;
      s1_z_r    <= in_coord_z;
      s1_idx_r  <= in_point_index;
      s2_cmd_r  <= s1_cmd_r;
      s2_ok_r   <= ok2_nxt;
      s2_x_r    <= x2_nxt;
      s2_y_r    <= y2_nxt;
      s2_z_r    <= z2_nxt;
      s2_t_r    <= t2_nxt;
      s2_idx_r  <= s1_idx_r;
      s3_data_r <= {s2_cmd_r, ok3_nxt, idx3_nxt, s2_x_r, s2_y_r, s2_z_r};
    end
  end

endmodule

// ===== design/gicc_queue.sv =====
// ----------------------------------------------------------------------------
// gicc_queue
// small fifo between the front and back halves
// ----------------------------------------------------------------------------
module gicc_queue import gicc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output gicc_q_stat_t     q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/gicc_back.sv =====
// ----------------------------------------------------------------------------
// gicc_back
// pipelined index division, position arithmetic and output register
// ----------------------------------------------------------------------------
module gicc_back import gicc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gicc_q_stat_t                    q_stat,
  output logic                            pop,
  input  logic [2+IDX_W+3*$clog2(MAX_DIM)-1:0] pop_data,
  input  logic [$clog2(MAX_DIM+1)-1:0]    nx,
  input  logic [2*$clog2(MAX_DIM+1)-1:0]  xy,
  input  logic [SPC_W-1:0]                spacing,
  input  logic [ORG_W-1:0]                origin_x,
  input  logic [ORG_W-1:0]                origin_y,
  input  logic [ORG_W-1:0]                origin_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [IDX_W-1:0]                out_index_out,
  output logic [CRD_W-1:0]                out_x_out,
  output logic [CRD_W-1:0]                out_y_out,
  output logic [CRD_W-1:0]                out_z_out,
  output logic [POS_W-1:0]                out_pos_x,
  output logic [POS_W-1:0]                out_pos_y,
  output logic [POS_W-1:0]                out_pos_z,
  output logic                            out_error_code
);

  localparam int SZ_W = $clog2(MAX_DIM+1);
  localparam int Q    = $clog2(MAX_DIM);
  localparam int NST  = 2 * Q;
  localparam int LST  = NST - 1;
  localparam int DZ_W = 2*SZ_W + Q;
  localparam int CW   = (DZ_W > IDX_W) ? DZ_W : IDX_W;
  localparam int M_W  = Q + SPC_W;

  logic en;

  logic             st_v_r   [NST];
  logic             st_cmd_r [NST];
  logic             st_ok_r  [NST];
  logic [IDX_W-1:0] st_idx_r [NST];
  logic [Q-1:0]     st_x_r   [NST];
  logic [Q-1:0]     st_y_r   [NST];
  logic [Q-1:0]     st_z_r   [NST];
  logic [IDX_W-1:0] st_rem_r [NST];
  logic [Q-1:0]     st_qz_r  [NST];
  logic [Q-1:0]     st_qy_r  [NST];

  logic             src_cmd  [NST];
  logic             src_ok   [NST];
  logic [IDX_W-1:0] src_idx  [NST];
  logic [Q-1:0]     src_x    [NST];
  logic [Q-1:0]     src_y    [NST];
  logic [Q-1:0]     src_z    [NST];
  logic [IDX_W-1:0] src_rem  [NST];
  logic [Q-1:0]     src_qz   [NST];
  logic [Q-1:0]     src_qy   [NST];
  logic [IDX_W-1:0] rem_nxt  [NST];
  logic [Q-1:0]     qz_nxt   [NST];
  logic [Q-1:0]     qy_nxt   [NST];

  logic             q_cmd, q_ok;
  logic [IDX_W-1:0] q_idx;
  logic [Q-1:0]     q_x, q_y, q_z;

  logic [Q-1:0]     cx, cy, cz;
  logic [M_W-1:0]   mx, my, mz;
  logic signed [ORG_W-1:0] ox, oy, oz;

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_stat.empty;
  assign {q_cmd, q_ok, q_idx, q_x, q_y, q_z} = pop_data;

  // one quotient bit per stage: z bits against xy, then y bits against nx
  always_comb begin
    logic [CW-1:0] dvs;
    logic [CW-1:0] r;
    logic          b;
    for (int i = 0; i < NST; i++) begin
      if (i == 0) begin
        src_cmd[i] = q_cmd;
        src_ok[i]  = q_ok;
        src_idx[i] = q_idx;
        src_x[i]   = q_x;
        src_y[i]   = q_y;
        src_z[i]   = q_z;
        src_rem[i] = q_idx;
        src_qz[i]  = '0;
        src_qy[i]  = '0;
      end else begin
        src_cmd[i] = st_cmd_r[i-1];
        src_ok[i]  = st_ok_r[i-1];
        src_idx[i] = st_idx_r[i-1];
        src_x[i]   = st_x_r[i-1];
        src_y[i]   = st_y_r[i-1];
        src_z[i]   = st_z_r[i-1];
        src_rem[i] = st_rem_r[i-1];
        src_qz[i]  = st_qz_r[i-1];
        src_qy[i]  = st_qy_r[i-1];
      end
      if (i < Q) begin
        dvs = CW'(xy) << (Q - 1 - i);
      end else begin
        dvs = CW'(nx) << (NST - 1 - i);
      end
      r = CW'(src_rem[i]);
      b = (r >= dvs);
      rem_nxt[i] = b ? IDX_W'(r - dvs) : src_rem[i];
      if (i < Q) begin
        qz_nxt[i] = (src_qz[i] << 1) | Q'(b);
        qy_nxt[i] = src_qy[i];
      end else begin
        qz_nxt[i] = src_qz[i];
        qy_nxt[i] = (src_qy[i] << 1) | Q'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        st_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      st_v_r[0] <= !q_stat.empty;
      for (int i = 1; i < NST; i++) begin
        st_v_r[i] <= st_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        st_cmd_r[i] <= src_cmd[i];
        st_ok_r[i]  <= src_ok[i];
        st_idx_r[i] <= src_idx[i];
        st_x_r[i]   <= src_x[i];
        st_y_r[i]   <= src_y[i];
        st_z_r[i]   <= src_z[i];
        st_rem_r[i] <= rem_nxt[i];
        st_qz_r[i]  <= qz_nxt[i];
        st_qy_r[i]  <= qy_nxt[i];
      end
    end
  end

  // coordinates from the divider or as given, then origin + c*spacing
  always_comb begin
    if (st_cmd_r[LST] == CMD_TO_COORD) begin
      cx = Q'(st_rem_r[LST]);
      cy = st_qy_r[LST];
      cz = st_qz_r[LST];
    end else begin
      cx = st_x_r[LST];
      cy = st_y_r[LST];
      cz = st_z_r[LST];
    end
    mx = M_W'(cx) * M_W'(spacing);
    my = M_W'(cy) * M_W'(spacing);
    mz = M_W'(cz) * M_W'(spacing);
    ox = origin_x;
    oy = origin_y;
    oz = origin_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_v_r[LST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st_ok_r[LST]) begin
        out_index_out  <= st_idx_r[LST];
        out_x_out      <= CRD_W'(cx);
        out_y_out      <= CRD_W'(cy);
        out_z_out      <= CRD_W'(cz);
        out_pos_x      <= POS_W'(ox) + POS_W'(mx);
        out_pos_y      <= POS_W'(oy) + POS_W'(my);
        out_pos_z      <= POS_W'(oz) + POS_W'(mz);
        out_error_code <= ERR_NONE;
      end else begin
        out_index_out  <= '0;
        out_x_out      <= '0;
        out_y_out      <= '0;
        out_z_out      <= '0;
        out_pos_x      <= '0;
        out_pos_y      <= '0;
        out_pos_z      <= '0;
        out_error_code <= ERR_OUTSIDE;
      end
    end
  end

endmodule

// ===== design/grid_index_coordinate_converter.sv =====
// ----------------------------------------------------------------------------
// grid_index_coordinate_converter
// row-major 3d grid index <-> coordinates, with fixed-point positions
// ----------------------------------------------------------------------------
// path: front stages, the queue, the one-bit-per-stage index divider and the output register
// throughput: one beat per cycle, any mix of commands, unless out_ready holds results back
// reset: synchronous, active low; clears the pipeline and queue and loads
//   sizes 2, spacing 1.0 and origins 0
module grid_index_coordinate_converter import gicc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [COORD_W-1:0]   in_coord_x,
  input  logic [COORD_W-1:0]   in_coord_y,
  input  logic [COORD_W-1:0]   in_coord_z,
  input  logic [IDX_W-1:0]     in_point_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_index_out,
  output logic [CRD_W-1:0]     out_x_out,
  output logic [CRD_W-1:0]     out_y_out,
  output logic [CRD_W-1:0]     out_z_out,
  output logic [POS_W-1:0]     out_pos_x,
  output logic [POS_W-1:0]     out_pos_y,
  output logic [POS_W-1:0]     out_pos_z,
  output logic                 out_error_code
);

  localparam int SZ_W  = $clog2(MAX_DIM+1);
  localparam int CQ_W  = $clog2(MAX_DIM);
  localparam int XY_W  = 2 * SZ_W;
  localparam int TOT_W = 3 * SZ_W;
  localparam int ENT_W = 2 + IDX_W + 3*CQ_W;

  // configuration registers
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [SPC_W-1:0]  spacing_r;
  logic [ORG_W-1:0]  origin_x_r, origin_y_r, origin_z_r;

  // sizes clamped to [2, MAX_DIM], and the plane and volume products
  logic [SZ_W-1:0]  nx, ny, nz;
  logic [XY_W-1:0]  xy_r;
  logic [TOT_W-1:0] total_r;

  // queue between front and back
  gicc_q_stat_t     q_stat;
  logic             push, pop;
  logic [ENT_W-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r   <= SIZE_W'(RESET_SIZE);
      size_y_r   <= SIZE_W'(RESET_SIZE);
      size_z_r   <= SIZE_W'(RESET_SIZE);
      spacing_r  <= SPC_W'(RESET_SPACING);
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X:   size_x_r   <= SIZE_W'(cfg_wdata);
        REG_SIZE_Y:   size_y_r   <= SIZE_W'(cfg_wdata);
        REG_SIZE_Z:   size_z_r   <= SIZE_W'(cfg_wdata);
        REG_SPACING:  spacing_r  <= SPC_W'(cfg_wdata);
        REG_ORIGIN_X: origin_x_r <= ORG_W'(cfg_wdata);
        REG_ORIGIN_Y: origin_y_r <= ORG_W'(cfg_wdata);
        REG_ORIGIN_Z: origin_z_r <= ORG_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // out-of-range sizes saturate
  always_comb begin
    nx = (32'(size_x_r) < SIZE_MIN) ? SZ_W'(SIZE_MIN) :
         (32'(size_x_r) > MAX_DIM)  ? SZ_W'(MAX_DIM)  : SZ_W'(size_x_r);
    ny = (32'(size_y_r) < SIZE_MIN) ? SZ_W'(SIZE_MIN) :
         (32'(size_y_r) > MAX_DIM)  ? SZ_W'(MAX_DIM)  : SZ_W'(size_y_r);
    nz = (32'(size_z_r) < SIZE_MIN) ? SZ_W'(SIZE_MIN) :
         (32'(size_z_r) > MAX_DIM)  ? SZ_W'(MAX_DIM)  : SZ_W'(size_z_r);
  end

  // products are registered: xy_r from the clamped sizes, then total_r from xy_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xy_r    <= XY_W'(RESET_SIZE * RESET_SIZE);
      total_r <= TOT_W'(RESET_SIZE * RESET_SIZE * RESET_SIZE);
    end else begin
      xy_r    <= XY_W'(nx) * XY_W'(ny);
      total_r <= TOT_W'(xy_r) * TOT_W'(nz);
    end
  end

  // front: accept, range check, linearize
  gicc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_point_index (in_point_index),
    .nx             (nx),
    .ny             (ny),
    .nz             (nz),
    .total          (total_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  gicc_queue #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: divide the index, form positions, hold the result beat
  gicc_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop            (pop),
    .pop_data       (pop_data),
    .nx             (nx),
    .xy             (xy_r),
    .spacing        (spacing_r),
    .origin_x       (origin_x_r),
    .origin_y       (origin_y_r),
    .origin_z       (origin_z_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_index_out  (out_index_out),
    .out_x_out      (out_x_out),
    .out_y_out      (out_y_out),
    .out_z_out      (out_z_out),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_error_code (out_error_code)
  );

endmodule

// ===== design/gicc_checker.sv =====
// ----------------------------------------------------------------------------
// gicc_checker
// port-level checks of the grid index converter, bound to the top level
// ----------------------------------------------------------------------------
module gicc_checker import gicc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [IDX_W-1:0]     out_index_out,
  input logic [CRD_W-1:0]     out_x_out,
  input logic [CRD_W-1:0]     out_y_out,
  input logic [CRD_W-1:0]     out_z_out,
  input logic [POS_W-1:0]     out_pos_x,
  input logic [POS_W-1:0]     out_pos_y,
  input logic [POS_W-1:0]     out_pos_z,
  input logic                 out_error_code
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index_out) &&
    $stable(out_x_out) && $stable(out_pos_x) && $stable(out_error_code))
    else $error("result beat changed while stalled");

  // an error beat carries only zeros
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_OUTSIDE) |->
    (out_index_out == '0) && (out_x_out == '0) && (out_y_out == '0) &&
    (out_z_out == '0) && (out_pos_x == '0) && (out_pos_y == '0) &&
    (out_pos_z == '0))
    else $error("error beat with nonzero fields");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input back-pressure only comes from a waiting result
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind grid_index_coordinate_converter gicc_checker u_gicc_checker (.*);

// ===== tb/sv/tb_grid_index_coordinate_converter.sv =====
// ----------------------------------------------------------------------------
// tb_grid_index_coordinate_converter
// drives coordinate and index beats through the converter under several grid
// settings and checks every result beat against an in-bench prediction
// ----------------------------------------------------------------------------
module tb_grid_index_coordinate_converter import gicc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 24;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] z;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic             err;
  } point_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [COORD_W-1:0]   in_coord_x, in_coord_y, in_coord_z;
  logic [IDX_W-1:0]     in_point_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_W-1:0]     out_index_out;
  logic [CRD_W-1:0]     out_x_out, out_y_out, out_z_out;
  logic [POS_W-1:0]     out_pos_x, out_pos_y, out_pos_z;
  logic                 out_error_code;

  grid_index_coordinate_converter i_dut (.*);

  // shadow copy of the grid registers
  logic [SIZE_W-1:0] grid_nx, grid_ny, grid_nz;
  logic [SPC_W-1:0]  grid_spc;
  logic [ORG_W-1:0]  grid_org [3];

  point_t expected_points [$];
  int     mismatches = 0;
  int     wdog = 0;
  bit     stall_random;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturated axis size
  function automatic longint unsigned axis_size(logic [SIZE_W-1:0] s);
    if (s < SIZE_MIN) return SIZE_MIN;
    if (s > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return s;
  endfunction

  function automatic logic [POS_W-1:0] axis_pos(logic [ORG_W-1:0] org, longint unsigned c);
    logic signed [63:0] o;
    o = {{24{org[ORG_W-1]}}, org};
    return POS_W'(o + 64'(c) * 64'(grid_spc));
  endfunction

  // expected result of one beat under the current grid
  function automatic point_t convert_point(logic cmd, logic [COORD_W-1:0] cx,
                                           logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz,
                                           logic [IDX_W-1:0] pidx);
    point_t p;
    longint unsigned nx, ny, nz, x, y, z, idx, rem;
    bit ok;
    nx = axis_size(grid_nx);
    ny = axis_size(grid_ny);
    nz = axis_size(grid_nz);
    p = '0;
    if (cmd == CMD_TO_INDEX) begin
      ok = !cx[COORD_W-1] && !cy[COORD_W-1] && !cz[COORD_W-1] &&
           cx < nx && cy < ny && cz < nz;
      x = cx; y = cy; z = cz;
      idx = x + nx * (y + ny * z);
    end else begin
      idx = pidx;
      ok = idx < nx * ny * nz;
      z = idx / (nx * ny);
      rem = idx % (nx * ny);
      y = rem / nx;
      x = rem % nx;
    end
    if (!ok) begin
      p.err = ERR_OUTSIDE;
      return p;
    end
    p.idx = IDX_W'(idx);
    p.x = CRD_W'(x);
    p.y = CRD_W'(y);
    p.z = CRD_W'(z);
    p.px = axis_pos(grid_org[0], x);
    p.py = axis_pos(grid_org[1], y);
    p.pz = axis_pos(grid_org[2], z);
    p.err = ERR_NONE;
    return p;
  endfunction

  // register write, mirrored into the shadow copy; only used while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_SIZE_X:   grid_nx = val[SIZE_W-1:0];
      REG_SIZE_Y:   grid_ny = val[SIZE_W-1:0];
      REG_SIZE_Z:   grid_nz = val[SIZE_W-1:0];
      REG_SPACING:  grid_spc = val[SPC_W-1:0];
      REG_ORIGIN_X: grid_org[0] = val[ORG_W-1:0];
      REG_ORIGIN_Y: grid_org[1] = val[ORG_W-1:0];
      REG_ORIGIN_Z: grid_org[2] = val[ORG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_grid(int nx, int ny, int nz, logic [SPC_W-1:0] spc,
                          logic [ORG_W-1:0] ox, logic [ORG_W-1:0] oy,
                          logic [ORG_W-1:0] oz);
    write_reg(REG_SIZE_X, CFG_W'(nx));
    write_reg(REG_SIZE_Y, CFG_W'(ny));
    write_reg(REG_SIZE_Z, CFG_W'(nz));
    write_reg(REG_SPACING, CFG_W'(spc));
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
  endtask

  // send one beat, holding it until accepted; valid stays high into the next
  // beat when no gap follows, so it is never dropped and raised in one step
  task automatic send_beat(logic cmd, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           logic [COORD_W-1:0] cz, logic [IDX_W-1:0] pidx);
    in_valid = 1'b1;
    in_cmd = cmd;
    in_coord_x = cx;
    in_coord_y = cy;
    in_coord_z = cz;
    in_point_index = pidx;
    do @(posedge clk); while (!in_ready);
    expected_points.push_back(convert_point(cmd, cx, cy, cz, pidx));
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_coord(int x, int y, int z);
    send_beat(CMD_TO_INDEX, COORD_W'(x), COORD_W'(y), COORD_W'(z), IDX_W'($urandom));
  endtask

  task automatic send_index(longint unsigned idx);
    send_beat(CMD_TO_COORD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              IDX_W'(idx));
  endtask

  // wait for every result, then let the pipeline drain
  task automatic drain;
    idle_gap(1);
    while (expected_points.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // random coordinate, mostly inside the grid, sometimes just outside or wild
  function automatic int pick_coord(longint unsigned n);
    case ($urandom_range(9))
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'(n);
      2: return -1;
      default: return $urandom_range(int'(n) - 1);
    endcase
  endfunction

  task automatic random_burst(int count);
    longint unsigned nx, ny, nz;
    int gap;
    nx = axis_size(grid_nx);
    ny = axis_size(grid_ny);
    nz = axis_size(grid_nz);
    gap = 0;
    for (int i = 0; i < count; i++) begin
      if (gap == 0 && $urandom_range(5) == 0) idle_gap($urandom_range(1, 6));
      if ($urandom_range(1)) begin
        send_coord(pick_coord(nx), pick_coord(ny), pick_coord(nz));
      end else begin
        case ($urandom_range(7))
          0: send_index($urandom);
          1: send_index(nx * ny * nz);
          2: send_index(nx * ny * nz - 1);
          default: send_index($urandom_range(int'(nx * ny * nz) - 1));
        endcase
      end
      gap = (gap == 0) ? $urandom_range(0, 12) : gap - 1;
    end
  endtask

  // field extremes and the error cases under the reset grid
  task automatic test_reset_grid;
    send_coord(0, 0, 0);
    send_coord(1, 1, 1);
    send_coord(2, 0, 0);
    send_coord(0, -1, 0);
    send_coord(-32768, 32767, 0);
    send_coord(32767, 0, -32768);
    send_beat(CMD_TO_INDEX, '1, '1, '1, '1);
    send_index(0);
    send_index(7);
    send_index(8);
    send_index(30'h3fff_ffff);
    drain();
  endtask

  // size saturation, zero spacing, widest grid and extreme origins
  task automatic test_extremes;
    set_grid(0, 1, 2047, 24'd0, 40'h80_0000_0000, 40'h7f_ffff_ffff, 40'h0);
    send_coord(1, 1, 1023);
    send_coord(0, 0, 1024);
    send_index(4095);
    send_index(4096);
    drain();
    set_grid(1024, 1024, 1024, 24'hff_ffff, 40'h7f_ffff_ffff, 40'h80_0000_0000,
             40'hff_ffff_ffff);
    send_coord(1023, 1023, 1023);
    send_coord(1024, 0, 0);
    send_index(30'h3fff_ffff);
    send_index(0);
    send_index(30'h2aaa_aaaa);
    send_index(30'h1555_5555);
    drain();
  endtask

  task automatic test_random_grids;
    for (int phase = 0; phase < 6; phase++) begin
      stall_random = (phase % 3) != 2;
      set_grid($urandom_range(phase == 5 ? 1024 : 40), $urandom_range(40),
               $urandom_range(phase == 0 ? 2047 : 40), SPC_W'($urandom),
               ORG_W'({$urandom, $urandom}),
               ORG_W'({$urandom, $urandom}),
               ORG_W'({$urandom, $urandom}));
      random_burst(80);
      drain();
    end
  endtask

  // receiver: stalls on its own bursty pattern while stall_random is set
  initial begin
    int run;
    out_ready = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        run = $urandom_range(1, 10);
        out_ready = stall_random ? $urandom_range(2) != 0 : 1'b1;
      end else begin
        run--;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_index_out, out_x_out, out_y_out, out_z_out,
              out_pos_x, out_pos_y, out_pos_z, out_error_code};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: idx %h/%h x %h/%h y %h/%h z %h/%h",
                      " px %h/%h py %h/%h pz %h/%h err %b/%b"},
                     want.idx, got.idx, want.x, got.x, want.y, got.y, want.z, got.z,
                     want.px, got.px, want.py, got.py, want.pz, got.pz, want.err, got.err);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or config write while work is pending
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we ||
        (!in_valid && expected_points.size() == 0)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("FAIL grid_index_coordinate_converter");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_point_index = '0;
    stall_random = 1'b1;
    grid_nx = SIZE_W'(RESET_SIZE);
    grid_ny = SIZE_W'(RESET_SIZE);
    grid_nz = SIZE_W'(RESET_SIZE);
    grid_spc = SPC_W'(RESET_SPACING);
    grid_org[0] = '0;
    grid_org[1] = '0;
    grid_org[2] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_grid();
    test_extremes();
    test_random_grids();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("PASS grid_index_coordinate_converter");
    end else begin
      $display("FAIL grid_index_coordinate_converter");
    end
    $finish;
  end

endmodule
